>>> design/rdl_pkg.sv
// Shared types and constants for the radix dictionary lookup block.
package rdl_pkg;

    localparam int NODE_W     = 6;
    localparam int NODES      = 64;
    localparam int LEN_W      = 6;
    localparam int KEY_LEN    = 32;
    localparam int BYTE_IDX_W = 5;
    localparam int POS_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int NAME_AW    = NODE_W + BYTE_IDX_W;
    localparam int NAMES      = NODES * KEY_LEN;

    typedef enum logic [1:0] {
        CMD_NODE   = 2'd0,
        CMD_NAME   = 2'd1,
        CMD_KEY    = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RES_FOUND = 2'd0,
        RES_RANGE = 2'd1,
        RES_LEN   = 2'd2,
        RES_BYTE  = 2'd3
    } res_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_NODE,
        S_KEY,
        S_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [NODE_W-1:0]       left;
        logic [NODE_W-1:0]       right;
        logic [LEN_W-1:0]        len;
    } node_t;

    typedef struct packed {
        logic      accept;
        logic      lk_start;
        logic      root_eval;
        logic      node_eval;
        logic      key_eval;
        logic      cmp_start;
        logic      cmp_step;
        logic      set_res;
        res_code_t res_code;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic root_fail;
        logic walk_end;
        logic len_bad;
        logic len_zero;
        logic child_fail;
        logic byte_bad;
        logic cmp_last;
        logic out_busy;
    } dp_status_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        sat_len = (v > LEN_W'(KEY_LEN)) ? LEN_W'(KEY_LEN) : v;
    endfunction

endpackage

>>> design/radix_dictionary_lookup.sv
// Patricia-trie dictionary lookup: top level with register port, sequencer and datapath.
// Write requests (node, name byte, key byte) are taken in the idle state. A lookup request
// walks the trie by child steps and, on a length match, compares the name; each step reads
// the node table and then the key buffer, and the name compare reads one byte per cycle. A
// finished result sits in an output register, so the next request is taken while it waits.
// node_count (offset 0) bounds the valid child indices, 0 to node_count.
module radix_dictionary_lookup (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic [rdl_pkg::NODE_W-1:0]       s_node_index,
    input  logic signed [rdl_pkg::POS_W-1:0] s_ref_bit,
    input  logic [rdl_pkg::NODE_W-1:0]       s_left_index,
    input  logic [rdl_pkg::NODE_W-1:0]       s_right_index,
    input  logic [rdl_pkg::LEN_W-1:0]        s_length,
    input  logic [rdl_pkg::BYTE_IDX_W-1:0]   s_byte_index,
    input  logic [rdl_pkg::BYTE_W-1:0]       s_byte_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [rdl_pkg::NODE_W-1:0]       m_found_node
);

    logic [rdl_pkg::NODE_W-1:0] node_count_reg;
    rdl_pkg::dp_cmd_t           cmd;
    rdl_pkg::dp_status_t        sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            node_count_reg <= pwdata[rdl_pkg::NODE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-rdl_pkg::NODE_W){1'b0}}, node_count_reg};

    rdl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rdl_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .node_count    (node_count_reg),
        .s_cmd         (s_cmd),
        .s_node_index  (s_node_index),
        .s_ref_bit     (s_ref_bit),
        .s_left_index  (s_left_index),
        .s_right_index (s_right_index),
        .s_length      (s_length),
        .s_byte_index  (s_byte_index),
        .s_byte_value  (s_byte_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_node  (m_found_node)
    );

endmodule

>>> design/rdl_ctrl.sv
// Lookup sequencer: walks the trie, then compares the name, then delivers the result.
module rdl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_cmd,
    output logic                s_ready,
    input  rdl_pkg::dp_status_t sts,
    output rdl_pkg::dp_cmd_t    cmd
);

    rdl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rdl_pkg::S_IDLE: begin
                if (s_valid && s_cmd == rdl_pkg::CMD_LOOKUP) begin
                    state_next = rdl_pkg::S_ROOT;
                end
            end
            rdl_pkg::S_ROOT: begin
                state_next = sts.root_fail ? rdl_pkg::S_DONE : rdl_pkg::S_NODE;
            end
            rdl_pkg::S_NODE: begin
                if (!sts.walk_end) begin
                    state_next = rdl_pkg::S_KEY;
                end else if (sts.len_bad || sts.len_zero) begin
                    state_next = rdl_pkg::S_DONE;
                end else begin
                    state_next = rdl_pkg::S_CMP;
                end
            end
            rdl_pkg::S_KEY: begin
                state_next = sts.child_fail ? rdl_pkg::S_DONE : rdl_pkg::S_NODE;
            end
            rdl_pkg::S_CMP: begin
                if (sts.byte_bad || sts.cmp_last) begin
                    state_next = rdl_pkg::S_DONE;
                end
            end
            rdl_pkg::S_DONE: begin
                if (!sts.out_busy) begin
                    state_next = rdl_pkg::S_IDLE;
                end
            end
            default: state_next = rdl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.res_code = rdl_pkg::RES_FOUND;
        s_ready      = 1'b0;
        case (state_reg)
            rdl_pkg::S_IDLE: begin
                s_ready      = 1'b1;
                cmd.accept   = s_valid;
                cmd.lk_start = s_valid && s_cmd == rdl_pkg::CMD_LOOKUP;
            end
            rdl_pkg::S_ROOT: begin
                cmd.root_eval = 1'b1;
                if (sts.root_fail) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = rdl_pkg::RES_RANGE;
                end
            end
            rdl_pkg::S_NODE: begin
                if (!sts.walk_end) begin
                    cmd.node_eval = 1'b1;
                end else if (sts.len_bad) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = rdl_pkg::RES_LEN;
                end else if (sts.len_zero) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = rdl_pkg::RES_FOUND;
                end else begin
                    cmd.cmp_start = 1'b1;
                end
            end
            rdl_pkg::S_KEY: begin
                cmd.key_eval = 1'b1;
                if (sts.child_fail) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = rdl_pkg::RES_RANGE;
                end
            end
            rdl_pkg::S_CMP: begin
                if (sts.byte_bad) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = rdl_pkg::RES_BYTE;
                end else if (sts.cmp_last) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = rdl_pkg::RES_FOUND;
                end else begin
                    cmd.cmp_step = 1'b1;
                end
            end
            rdl_pkg::S_DONE: begin
                cmd.out_load = !sts.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/rdl_dpath.sv
// Node table, name store, key buffer, walk registers and result register.
module rdl_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rdl_pkg::dp_cmd_t                      cmd,
    output rdl_pkg::dp_status_t                   sts,
    input  logic [rdl_pkg::NODE_W-1:0]            node_count,
    input  logic [1:0]                            s_cmd,
    input  logic [rdl_pkg::NODE_W-1:0]            s_node_index,
    input  logic signed [rdl_pkg::POS_W-1:0]      s_ref_bit,
    input  logic [rdl_pkg::NODE_W-1:0]            s_left_index,
    input  logic [rdl_pkg::NODE_W-1:0]            s_right_index,
    input  logic [rdl_pkg::LEN_W-1:0]             s_length,
    input  logic [rdl_pkg::BYTE_IDX_W-1:0]        s_byte_index,
    input  logic [rdl_pkg::BYTE_W-1:0]            s_byte_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic [rdl_pkg::NODE_W-1:0]            m_found_node
);

    rdl_pkg::node_t                      node_mem [rdl_pkg::NODES];
    logic [rdl_pkg::BYTE_W-1:0]          name_mem [rdl_pkg::NAMES];
    logic [rdl_pkg::BYTE_W-1:0]          key_mem  [rdl_pkg::KEY_LEN];

    rdl_pkg::node_t                      node_rd_reg;
    logic [rdl_pkg::BYTE_W-1:0]          name_rd_reg;
    logic [rdl_pkg::BYTE_W-1:0]          key_rd_reg;

    logic [rdl_pkg::LEN_W-1:0]           klen_reg;
    logic signed [rdl_pkg::POS_W-1:0]    prev_pos_reg;
    logic signed [rdl_pkg::POS_W-1:0]    cur_pos_reg;
    logic [rdl_pkg::NODE_W-1:0]          cur_left_reg;
    logic [rdl_pkg::NODE_W-1:0]          cur_right_reg;
    logic                                key_ok_reg;
    logic [rdl_pkg::NODE_W-1:0]          cur_reg;
    logic [rdl_pkg::BYTE_IDX_W-1:0]      idx_reg;
    rdl_pkg::res_code_t                  res_reg;
    logic                                m_valid_reg, m_valid_next;
    logic [1:0]                          m_status_reg;
    logic [rdl_pkg::NODE_W-1:0]          m_node_reg;

    logic [rdl_pkg::NODE_W-1:0]          node_addr;
    logic [rdl_pkg::BYTE_IDX_W-1:0]      cmp_idx;
    logic [rdl_pkg::BYTE_IDX_W-1:0]      key_addr;
    logic [rdl_pkg::BYTE_IDX_W-1:0]      back;
    logic [rdl_pkg::LEN_W-1:0]           back_addr;
    logic                                key_ok;
    logic                                key_bit;
    logic [rdl_pkg::NODE_W-1:0]          next_idx;

    always_comb begin
        back      = node_rd_reg.pos[rdl_pkg::BYTE_IDX_W+2:3];
        key_ok    = !node_rd_reg.pos[rdl_pkg::POS_W-1]
                    && ({1'b0, back} < klen_reg);
        back_addr = klen_reg - rdl_pkg::LEN_W'(1) - {1'b0, back};
        key_bit   = key_ok_reg && key_rd_reg[cur_pos_reg[2:0]];
        next_idx  = key_bit ? cur_right_reg : cur_left_reg;
        cmp_idx   = cmd.cmp_start ? '0 : idx_reg + rdl_pkg::BYTE_IDX_W'(1);
        key_addr  = cmd.node_eval ? back_addr[rdl_pkg::BYTE_IDX_W-1:0] : cmp_idx;
        node_addr = '0;
        if (cmd.root_eval) begin
            node_addr = node_rd_reg.left;
        end else if (cmd.key_eval) begin
            node_addr = next_idx;
        end
    end

    always_comb begin
        sts.root_fail  = node_rd_reg.left > node_count;
        sts.walk_end   = !($signed(prev_pos_reg) < $signed(node_rd_reg.pos));
        sts.len_bad    = node_rd_reg.len != klen_reg;
        sts.len_zero   = klen_reg == '0;
        sts.child_fail = next_idx > node_count;
        sts.byte_bad   = name_rd_reg != key_rd_reg;
        sts.cmp_last   = ({1'b0, idx_reg} + rdl_pkg::LEN_W'(1)) == klen_reg;
        sts.out_busy   = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_cmd == rdl_pkg::CMD_NODE) begin
            node_mem[s_node_index] <= '{pos: s_ref_bit, left: s_left_index,
                                        right: s_right_index,
                                        len: rdl_pkg::sat_len(s_length)};
        end
        node_rd_reg <= node_mem[node_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_cmd == rdl_pkg::CMD_NAME) begin
            name_mem[{s_node_index, s_byte_index}] <= s_byte_value;
        end
        name_rd_reg <= name_mem[{cur_reg, cmp_idx}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_cmd == rdl_pkg::CMD_KEY) begin
            key_mem[s_byte_index] <= s_byte_value;
        end
        key_rd_reg <= key_mem[key_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.lk_start) begin
            klen_reg <= rdl_pkg::sat_len(s_length);
            cur_reg  <= '0;
        end
        if (cmd.root_eval) begin
            prev_pos_reg <= node_rd_reg.pos;
            if (!sts.root_fail) begin
                cur_reg <= node_rd_reg.left;
            end
        end
        if (cmd.node_eval) begin
            cur_pos_reg   <= node_rd_reg.pos;
            cur_left_reg  <= node_rd_reg.left;
            cur_right_reg <= node_rd_reg.right;
            key_ok_reg    <= key_ok;
        end
        if (cmd.key_eval) begin
            prev_pos_reg <= cur_pos_reg;
            if (!sts.child_fail) begin
                cur_reg <= next_idx;
            end
        end
        if (cmd.cmp_start) begin
            idx_reg <= '0;
        end else if (cmd.cmp_step) begin
            idx_reg <= cmp_idx;
        end
        if (cmd.set_res) begin
            res_reg <= cmd.res_code;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_reg;
            m_node_reg   <= cur_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found_node = m_node_reg;

endmodule

>>> design/rdl_checker.sv
// Port-level checks for the radix dictionary lookup, bound to the top level.
module rdl_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [1:0]                 s_cmd,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic [rdl_pkg::NODE_W-1:0] m_found_node
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_node))
        else $error("result changed while stalled");

    a_lookup_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == rdl_pkg::CMD_LOOKUP |=> !s_ready)
        else $error("request taken during a lookup");

    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd != rdl_pkg::CMD_LOOKUP |=> s_ready)
        else $error("write request stalled the block");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind radix_dictionary_lookup rdl_checker u_rdl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cmd        (s_cmd),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_found_node (m_found_node)
);

>>> bench/radix_dictionary_lookup_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for radix_dictionary_lookup: trie walks, name compares and the register port.
module radix_dictionary_lookup_tb;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1200;
    localparam int REPORT_MAX   = 10;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;

    typedef struct {
        rdl_pkg::cmd_t                    cmd;
        logic [rdl_pkg::NODE_W-1:0]       node_index;
        logic signed [rdl_pkg::POS_W-1:0] ref_bit;
        logic [rdl_pkg::NODE_W-1:0]       left_index;
        logic [rdl_pkg::NODE_W-1:0]       right_index;
        logic [rdl_pkg::LEN_W-1:0]        length;
        logic [rdl_pkg::BYTE_IDX_W-1:0]   byte_index;
        logic [rdl_pkg::BYTE_W-1:0]       byte_value;
    } request_t;

    typedef struct {
        rdl_pkg::res_code_t         status;
        logic [rdl_pkg::NODE_W-1:0] node;
    } lookup_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [2:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             s_valid;
    logic                             s_ready;
    logic [1:0]                       s_cmd;
    logic [rdl_pkg::NODE_W-1:0]       s_node_index;
    logic signed [rdl_pkg::POS_W-1:0] s_ref_bit;
    logic [rdl_pkg::NODE_W-1:0]       s_left_index;
    logic [rdl_pkg::NODE_W-1:0]       s_right_index;
    logic [rdl_pkg::LEN_W-1:0]        s_length;
    logic [rdl_pkg::BYTE_IDX_W-1:0]   s_byte_index;
    logic [rdl_pkg::BYTE_W-1:0]       s_byte_value;
    logic                             m_valid;
    logic                             m_ready;
    logic [1:0]                       m_status;
    logic [rdl_pkg::NODE_W-1:0]       m_found_node;

    logic signed [rdl_pkg::POS_W-1:0] trie_pos [rdl_pkg::NODES];
    logic [rdl_pkg::NODE_W-1:0]       trie_left [rdl_pkg::NODES];
    logic [rdl_pkg::NODE_W-1:0]       trie_right [rdl_pkg::NODES];
    logic [rdl_pkg::LEN_W-1:0]        trie_len [rdl_pkg::NODES];
    logic [rdl_pkg::BYTE_W-1:0]       trie_name [rdl_pkg::NODES][rdl_pkg::KEY_LEN];
    bit                               name_written [rdl_pkg::NODES][rdl_pkg::KEY_LEN];
    logic [rdl_pkg::BYTE_W-1:0]       key_buf [rdl_pkg::KEY_LEN];
    logic [rdl_pkg::NODE_W-1:0]       node_count_reg;

    lookup_result_t lookup_q[$];
    int mismatches  = 0;
    int sent_count  = 0;
    int tx_idle_pct = 12;
    int rx_idle_pct = 66;
    int rx_hold     = 0;
    int cycle_count;

    radix_dictionary_lookup dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_node_index  (s_node_index),
        .s_ref_bit     (s_ref_bit),
        .s_left_index  (s_left_index),
        .s_right_index (s_right_index),
        .s_length      (s_length),
        .s_byte_index  (s_byte_index),
        .s_byte_value  (s_byte_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_node  (m_found_node)
    );

    always #10 aclk = ~aclk;

    function automatic int clip_len(input logic [rdl_pkg::LEN_W-1:0] v);
        return (v > rdl_pkg::LEN_W'(rdl_pkg::KEY_LEN)) ? rdl_pkg::KEY_LEN : int'(v);
    endfunction

    function automatic bit key_bit(input int klen, input int pos);
        int back;
        if (pos < 0) return 1'b0;
        back = pos >> 3;
        if (back >= klen) return 1'b0;
        return key_buf[klen - 1 - back][pos & 7];
    endfunction

    function automatic void walk_trie(input logic [rdl_pkg::LEN_W-1:0] len_in,
                                      output lookup_result_t res, output bit unread);
        int klen, total, prev, cur, nxt, i;
        klen = clip_len(len_in);
        total = node_count_reg + 1;
        res.status = rdl_pkg::RES_FOUND;
        unread = 1'b0;
        prev = 0;
        cur = trie_left[0];
        if (cur >= total) begin
            res.status = rdl_pkg::RES_RANGE;
            cur = 0;
        end else begin
            while (trie_pos[prev] < trie_pos[cur]) begin
                prev = cur;
                nxt = key_bit(klen, trie_pos[cur]) ? trie_right[cur] : trie_left[cur];
                if (nxt >= total) begin
                    res.status = rdl_pkg::RES_RANGE;
                    break;
                end
                cur = nxt;
            end
        end
        if (res.status == rdl_pkg::RES_FOUND) begin
            if (trie_len[cur] != klen) begin
                res.status = rdl_pkg::RES_LEN;
            end else begin
                for (i = 0; i < klen; i++) begin
                    if (!name_written[cur][i]) begin
                        unread = 1'b1;
                        break;
                    end
                    if (trie_name[cur][i] != key_buf[i]) begin
                        res.status = rdl_pkg::RES_BYTE;
                        break;
                    end
                end
            end
        end
        res.node = cur[rdl_pkg::NODE_W-1:0];
    endfunction

    function automatic void apply_request(input request_t rq);
        lookup_result_t res;
        bit unread;
        case (rq.cmd)
            rdl_pkg::CMD_NODE: begin
                trie_pos[rq.node_index]   = rq.ref_bit;
                trie_left[rq.node_index]  = rq.left_index;
                trie_right[rq.node_index] = rq.right_index;
                trie_len[rq.node_index]   = rdl_pkg::LEN_W'(clip_len(rq.length));
            end
            rdl_pkg::CMD_NAME: begin
                trie_name[rq.node_index][rq.byte_index]    = rq.byte_value;
                name_written[rq.node_index][rq.byte_index] = 1'b1;
            end
            rdl_pkg::CMD_KEY: begin
                key_buf[rq.byte_index] = rq.byte_value;
            end
            default: begin
                walk_trie(rq.length, res, unread);
                lookup_q.push_back(res);
            end
        endcase
    endfunction

    function automatic request_t random_request(input rdl_pkg::cmd_t c);
        request_t rq;
        rq.cmd         = c;
        rq.node_index  = rdl_pkg::NODE_W'($urandom);
        rq.ref_bit     = rdl_pkg::POS_W'($urandom);
        rq.left_index  = rdl_pkg::NODE_W'($urandom);
        rq.right_index = rdl_pkg::NODE_W'($urandom);
        rq.length      = rdl_pkg::LEN_W'($urandom);
        rq.byte_index  = rdl_pkg::BYTE_IDX_W'($urandom);
        rq.byte_value  = rdl_pkg::BYTE_W'($urandom);
        return rq;
    endfunction

    function automatic logic [rdl_pkg::LEN_W-1:0] rand_key_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 55) return rdl_pkg::LEN_W'($urandom_range(1, 8));
        if (pick < 90) return rdl_pkg::LEN_W'($urandom_range(9, rdl_pkg::KEY_LEN));
        return rdl_pkg::LEN_W'($urandom_range(rdl_pkg::KEY_LEN + 1, 63));
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
    endtask

    task automatic send_request(input request_t rq);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= rq.cmd;
        s_node_index  <= rq.node_index;
        s_ref_bit     <= rq.ref_bit;
        s_left_index  <= rq.left_index;
        s_right_index <= rq.right_index;
        s_length      <= rq.length;
        s_byte_index  <= rq.byte_index;
        s_byte_value  <= rq.byte_value;
        do @(posedge aclk); while (!s_ready);
        apply_request(rq);
        sent_count++;
    endtask

    task automatic quiet_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        quiet_input();
        while (lookup_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr && addr == ADDR_NODE_COUNT) node_count_reg = wdata[rdl_pkg::NODE_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_node_count();
        logic [31:0] rd;
        reg_access(1'b0, ADDR_NODE_COUNT, 32'd0, rd);
        if (rd !== {26'd0, node_count_reg}) note_mismatch("node_count readback",
                                                          {26'd0, node_count_reg}, rd);
    endtask

    task automatic set_node_count(input int v);
        logic [31:0] rd;
        wait_drain();
        reg_access(1'b1, ADDR_NODE_COUNT, 32'(v), rd);
        check_node_count();
    endtask

    task automatic write_node(input int idx, input int pos, input int lft, input int rgt,
                              input int len);
        request_t rq;
        rq = random_request(rdl_pkg::CMD_NODE);
        rq.node_index  = rdl_pkg::NODE_W'(idx);
        rq.ref_bit     = rdl_pkg::POS_W'(pos);
        rq.left_index  = rdl_pkg::NODE_W'(lft);
        rq.right_index = rdl_pkg::NODE_W'(rgt);
        rq.length      = rdl_pkg::LEN_W'(len);
        send_request(rq);
    endtask

    task automatic write_key(input int idx, input int val);
        request_t rq;
        rq = random_request(rdl_pkg::CMD_KEY);
        rq.byte_index = rdl_pkg::BYTE_IDX_W'(idx);
        rq.byte_value = rdl_pkg::BYTE_W'(val);
        send_request(rq);
    endtask

    task automatic write_name(input int node, input int idx, input int val);
        request_t rq;
        rq = random_request(rdl_pkg::CMD_NAME);
        rq.node_index = rdl_pkg::NODE_W'(node);
        rq.byte_index = rdl_pkg::BYTE_IDX_W'(idx);
        rq.byte_value = rdl_pkg::BYTE_W'(val);
        send_request(rq);
    endtask

    function automatic int pick_child(input int i, input int n);
        if ($urandom_range(99) < 10) return $urandom_range(0, rdl_pkg::NODES - 1);
        if (i < n && $urandom_range(99) < 75) return $urandom_range(i + 1, n);
        return $urandom_range(0, i);
    endfunction

    // positions rise with node index, so forward children extend the walk
    task automatic build_trie(input int n);
        int i, step;
        step = (n > 0) ? 256 / n : 256;
        for (i = 0; i < rdl_pkg::NODES; i++) begin
            if (i == 0)
                write_node(0, -1, (n > 0) ? 1 : 0, $urandom_range(0, 63), $urandom_range(0, 8));
            else if (i <= n)
                write_node(i, (i - 1) * step + $urandom_range(0, step - 1), pick_child(i, n),
                           pick_child(i, n), $urandom_range(0, 8));
            else
                write_node(i, $urandom, $urandom, $urandom, $urandom_range(0, 8));
        end
    endtask

    task automatic run_lookup(input logic [rdl_pkg::LEN_W-1:0] len, input int found_pct);
        request_t rq;
        lookup_result_t res;
        bit unread;
        int klen, bad, i;
        klen = clip_len(len);
        walk_trie(len, res, unread);
        if (res.status != rdl_pkg::RES_RANGE && $urandom_range(99) < found_pct) begin
            write_node(res.node, trie_pos[res.node], trie_left[res.node], trie_right[res.node],
                       (klen == rdl_pkg::KEY_LEN && $urandom_range(1))
                           ? $urandom_range(rdl_pkg::KEY_LEN, 63) : klen);
            bad = ($urandom_range(99) < 25) ? $urandom_range(0, rdl_pkg::KEY_LEN - 1) : -1;
            for (i = 0; i < klen; i++)
                write_name(res.node, i,
                           (i == bad) ? key_buf[i] ^ rdl_pkg::BYTE_W'($urandom_range(1, 255))
                                      : key_buf[i]);
        end
        walk_trie(len, res, unread);
        if (unread) begin
            for (i = 0; i < trie_len[res.node]; i++)
                if (!name_written[res.node][i])
                    write_name(res.node, i, ($urandom_range(99) < 70) ? key_buf[i] : $urandom);
        end
        rq = random_request(rdl_pkg::CMD_LOOKUP);
        rq.length = len;
        send_request(rq);
    endtask

    task automatic load_tables();
        int i;
        set_node_count(63);
        build_trie(63);
        for (i = 0; i < rdl_pkg::KEY_LEN; i++) write_key(i, $urandom);
    endtask

    task automatic check_edge_cases();
        write_key(0, 8'hFF);
        write_key(rdl_pkg::KEY_LEN - 1, 8'h00);
        write_node(63, 255, 63, 0, 63);
        write_name(63, rdl_pkg::KEY_LEN - 1, 8'hFF);
        write_name(0, 0, 8'h00);
        write_node(62, -256, 0, 63, 32);
        run_lookup(rdl_pkg::LEN_W'(0), 50);
        run_lookup(rdl_pkg::LEN_W'(rdl_pkg::KEY_LEN), 50);
        run_lookup(rdl_pkg::LEN_W'(63), 50);
        run_lookup(rdl_pkg::LEN_W'(1), 100);
        set_node_count(0);
        write_node(0, -1, 1, 0, 0);
        run_lookup(rdl_pkg::LEN_W'(5), 0);
        write_node(0, -1, 0, 0, 0);
        run_lookup(rdl_pkg::LEN_W'(0), 0);
        run_lookup(rdl_pkg::LEN_W'(3), 0);
        set_node_count(1);
        write_node(0, -1, 1, 0, 0);
        run_lookup(rdl_pkg::LEN_W'(8), 0);
        set_node_count(63);
        write_node(0, -256, 62, 0, 2);
        write_node(62, -100, 63, 0, 4);
        run_lookup(rdl_pkg::LEN_W'(rdl_pkg::KEY_LEN), 50);
        run_lookup(rdl_pkg::LEN_W'(2), 50);
        write_node(0, -1, 1, 0, 0);
    endtask

    task automatic check_register_port();
        logic [31:0] rd;
        wait_drain();
        reg_access(1'b1, ADDR_UNUSED, $urandom, rd);
        check_node_count();
        set_node_count($urandom_range(1, 62));
        set_node_count(63);
    endtask

    task automatic check_output_stall();
        int i;
        rx_hold = 400;
        for (i = 0; i < 25; i++) run_lookup(rand_key_len(), 30);
        wait_drain();
    endtask

    task automatic check_random_traffic();
        int phase, start, pick, i;
        int counts[3];
        counts[0] = 63;
        counts[1] = $urandom_range(1, 15);
        counts[2] = $urandom_range(0, 63);
        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 66 : 0;
            rx_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 12 : 0;
            set_node_count(counts[phase]);
            start = sent_count;
            build_trie((phase == 2) ? $urandom_range(1, 63) : counts[phase]);
            while (sent_count - start < RANDOM_ITEMS / 3) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    if ($urandom_range(99) < 30)
                        for (i = $urandom_range(1, 3); i > 0; i--) write_key($urandom, $urandom);
                    run_lookup(rand_key_len(), 40);
                end else if (pick < 75) begin
                    write_node($urandom, $urandom, $urandom, $urandom, $urandom);
                end else if (pick < 88) begin
                    write_name($urandom, $urandom, $urandom);
                end else begin
                    write_key($urandom, $urandom);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lookup_q.size() == 0) begin
                note_mismatch("result with no request pending", 0, {30'd0, m_status});
            end else begin
                want = lookup_q.pop_front();
                if (m_status !== want.status)
                    note_mismatch("status", {30'd0, want.status}, {30'd0, m_status});
                if (m_found_node !== want.node)
                    note_mismatch("found_node", {26'd0, want.node}, {26'd0, m_found_node});
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("radix_dictionary_lookup_tb failed");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_cmd         = rdl_pkg::CMD_NODE;
        s_node_index  = '0;
        s_ref_bit     = '0;
        s_left_index  = '0;
        s_right_index = '0;
        s_length      = '0;
        s_byte_index  = '0;
        s_byte_value  = '0;
        node_count_reg = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        load_tables();
        check_edge_cases();
        check_register_port();
        check_output_stall();
        check_random_traffic();
        wait_drain();
        if (mismatches == 0 && lookup_q.size() == 0)
            $display("radix_dictionary_lookup_tb passed");
        else
            $display("radix_dictionary_lookup_tb failed");
        $finish;
    end

endmodule

>>> sim.f
design/rdl_pkg.sv
design/rdl_ctrl.sv
design/rdl_dpath.sv
design/radix_dictionary_lookup.sv
design/rdl_checker.sv
bench/radix_dictionary_lookup_tb.sv
